// ===== design/aps_pkg.sv =====
// Shared types and constants for the attachment point selector.
`timescale 1ns / 1ps

package aps_pkg;

  // Field widths
  localparam int unsigned IdxW   = 16;
  localparam int unsigned PosW   = 32;
  localparam int unsigned ExtW   = 31;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned RotW   = 4 * QuatW;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned MatW   = 22;   // rotation entry, Q16 signed
  localparam int unsigned ProdW  = MatW + PosW;

  // Indexes at or above this are echoed but never attached
  localparam int unsigned MaxParticles = 65536;

  // Rotation after reset: w = 1.0 in Q2.14
  localparam logic [RotW-1:0] RotReset = 64'h4000_0000_0000_0000;

  // Configuration register map
  typedef enum logic [2:0] {
    CfgBodyPosX   = 3'd0,
    CfgBodyPosY   = 3'd1,
    CfgBodyPosZ   = 3'd2,
    CfgBodyRot    = 3'd3,
    CfgShapeMode  = 3'd4,
    CfgExtentX    = 3'd5,
    CfgExtentY    = 3'd6,
    CfgExtentZ    = 3'd7
  } cfg_reg_e;

  // Shape selector codes; code 3 never attaches
  typedef enum logic [1:0] {
    ShapeBox      = 2'd0,
    ShapeSphere   = 2'd1,
    ShapeCylinder = 2'd2
  } shape_e;

  // Body-to-world rotation matrix, entries Q16 signed
  typedef struct packed {
    logic signed [MatW-1:0] r00;
    logic signed [MatW-1:0] r01;
    logic signed [MatW-1:0] r02;
    logic signed [MatW-1:0] r10;
    logic signed [MatW-1:0] r11;
    logic signed [MatW-1:0] r12;
    logic signed [MatW-1:0] r20;
    logic signed [MatW-1:0] r21;
    logic signed [MatW-1:0] r22;
  } rot_mat_t;

  localparam logic signed [MatW-1:0] MatOne  = MatW'(65536);
  localparam logic signed [MatW-1:0] MatZero = '0;

endpackage

// ===== design/aps_rot_matrix.sv =====
// Rotation matrix from the body quaternion, one register stage.
`timescale 1ns / 1ps

module aps_rot_matrix (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [aps_pkg::RotW-1:0] rot_i,   // w,x,y,z high to low, Q2.14
  output aps_pkg::rot_mat_t     mat_o
);
  import aps_pkg::*;

  localparam int unsigned EW = 35;  // Q4.28 entry with headroom

  logic signed [QuatW-1:0] qw, qa, qb, qc;
  logic signed [2*QuatW-1:0] p_aa, p_bb, p_cc, p_ab, p_ac, p_bc, p_wa, p_wb, p_wc;
  rot_mat_t mat_d, mat_q;

  // floor((e + 2^11) / 2^12)
  function automatic logic signed [MatW-1:0] round_ent(input logic signed [EW-1:0] e);
    logic signed [EW-1:0] t;
    t = e + EW'(2048);
    return t[MatW+11:12];
  endfunction

  function automatic logic signed [EW-1:0] diag(input logic signed [2*QuatW-1:0] s0,
                                               input logic signed [2*QuatW-1:0] s1);
    logic signed [EW-1:0] one;
    one = EW'(1) <<< 28;
    return one - ((EW'(s0) + EW'(s1)) <<< 1);
  endfunction

  function automatic logic signed [EW-1:0] offd(input logic signed [2*QuatW-1:0] s0,
                                               input logic signed [2*QuatW-1:0] s1,
                                               input logic sub);
    logic signed [EW-1:0] s;
    s = sub ? (EW'(s0) - EW'(s1)) : (EW'(s0) + EW'(s1));
    return s <<< 1;
  endfunction

  always_comb begin
    qw = rot_i[63:48];
    qa = rot_i[47:32];
    qb = rot_i[31:16];
    qc = rot_i[15:0];
    p_aa = qa * qa;
    p_bb = qb * qb;
    p_cc = qc * qc;
    p_ab = qa * qb;
    p_ac = qa * qc;
    p_bc = qb * qc;
    p_wa = qw * qa;
    p_wb = qw * qb;
    p_wc = qw * qc;
    mat_d.r00 = round_ent(diag(p_bb, p_cc));
    mat_d.r01 = round_ent(offd(p_ab, p_wc, 1'b1));
    mat_d.r02 = round_ent(offd(p_ac, p_wb, 1'b0));
    mat_d.r10 = round_ent(offd(p_ab, p_wc, 1'b0));
    mat_d.r11 = round_ent(diag(p_aa, p_cc));
    mat_d.r12 = round_ent(offd(p_bc, p_wa, 1'b1));
    mat_d.r20 = round_ent(offd(p_ac, p_wb, 1'b1));
    mat_d.r21 = round_ent(offd(p_bc, p_wa, 1'b0));
    mat_d.r22 = round_ent(diag(p_aa, p_bb));
  end

  // Reset value matches the identity rotation loaded at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '{r00: MatOne, r11: MatOne, r22: MatOne, default: MatZero};
    end else begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

// ===== design/attachment_point_selector.sv =====
// Top level: particle to body-frame transform and shape containment test.
`timescale 1ns / 1ps

// Attachment point selector. Each input beat carries one particle index and
// its world position (Q16.16). The block subtracts the body position
// (saturating), rotates the offset by the transpose of the rotation matrix
// built from the body quaternion, and flags whether the local point lies in
// the configured shape: box (inclusive, half extents), cylinder (strict,
// radius in extent_x, half height in extent_y compared to |y|), or sphere /
// code 3 (never attached). A result beat carries the index, the flag and the
// saturated local coordinates. Six register stages; one beat is taken
// every cycle while the output side keeps up, and a stall at the output
// holds every stage that has no free slot ahead of it. The rotation matrix
// and the squared radius are registered from the configuration registers in
// the cycle after a write, ahead of any beat taken after that write.
module attachment_point_selector (
  input  logic         clk_i,
  input  logic         rst_ni,

  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,

  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] particle_index, [47:16] particle_x, [79:48] particle_y,
  // [111:80] particle_z
  input  logic [111:0] s_axis_tdata,

  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] result_index, [16] attached, [48:17] local_x, [80:49] local_y,
  // [112:81] local_z, [119:113] zero
  output logic [119:0] m_axis_tdata
);
  import aps_pkg::*;

  localparam int unsigned SumW = ProdW + 2;
  localparam int unsigned ShW  = SumW - 16;
  localparam int unsigned SqW  = 2 * PosW;
  localparam int unsigned EsqW = 2 * ExtW;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [PosW-1:0] bpos_q [3];
  logic [RotW-1:0]        rot_q;
  logic [1:0]             shape_q;
  logic [ExtW-1:0]        ext_q [3];
  logic [EsqW-1:0]        ex_sq_q;
  rot_mat_t               mat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q[0] <= '0;
      bpos_q[1] <= '0;
      bpos_q[2] <= '0;
      rot_q     <= RotReset;
      shape_q   <= ShapeBox;
      ext_q[0]  <= '0;
      ext_q[1]  <= '0;
      ext_q[2]  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgBodyPosX:  bpos_q[0] <= cfg_data_i[PosW-1:0];
        CfgBodyPosY:  bpos_q[1] <= cfg_data_i[PosW-1:0];
        CfgBodyPosZ:  bpos_q[2] <= cfg_data_i[PosW-1:0];
        CfgBodyRot:   rot_q     <= cfg_data_i[RotW-1:0];
        CfgShapeMode: shape_q   <= cfg_data_i[1:0];
        CfgExtentX:   ext_q[0]  <= cfg_data_i[ExtW-1:0];
        CfgExtentY:   ext_q[1]  <= cfg_data_i[ExtW-1:0];
        CfgExtentZ:   ext_q[2]  <= cfg_data_i[ExtW-1:0];
        default: ;
      endcase
    end
  end

  // Squared cylinder radius, a registered copy of extent_x squared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_sq_q <= '0;
    end else begin
      ex_sq_q <= ext_q[0] * ext_q[0];
    end
  end

  aps_rot_matrix u_rot_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rot_i  (rot_q),
    .mat_o  (mat)
  );

  // ---------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its beat moves on
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_q || m_axis_tready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------
  logic [IdxW-1:0]        idx1_q;
  logic signed [PosW-1:0] p1_q [3];

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid) begin
      idx1_q  <= s_axis_tdata[15:0];
      p1_q[0] <= s_axis_tdata[47:16];
      p1_q[1] <= s_axis_tdata[79:48];
      p1_q[2] <= s_axis_tdata[111:80];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: offset from body, saturated to 32 bits
  // ---------------------------------------------------------------------
  logic [IdxW-1:0]        idx2_q;
  logic signed [PosW-1:0] d2_d [3];
  logic signed [PosW-1:0] d2_q [3];
  logic signed [PosW:0]   diff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (PosW+1)'(p1_q[i]) - (PosW+1)'(bpos_q[i]);
      if (diff[i][PosW] != diff[i][PosW-1]) begin
        d2_d[i] = diff[i][PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
      end else begin
        d2_d[i] = diff[i][PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      idx2_q <= idx1_q;
      d2_q   <= d2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: nine entry-by-offset products, local = R^T d
  // ---------------------------------------------------------------------
  logic [IdxW-1:0]         idx3_q;
  logic signed [ProdW-1:0] pr3_q [9];

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      idx3_q   <= idx2_q;
      pr3_q[0] <= mat.r00 * d2_q[0];
      pr3_q[1] <= mat.r10 * d2_q[1];
      pr3_q[2] <= mat.r20 * d2_q[2];
      pr3_q[3] <= mat.r01 * d2_q[0];
      pr3_q[4] <= mat.r11 * d2_q[1];
      pr3_q[5] <= mat.r21 * d2_q[2];
      pr3_q[6] <= mat.r02 * d2_q[0];
      pr3_q[7] <= mat.r12 * d2_q[1];
      pr3_q[8] <= mat.r22 * d2_q[2];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: row sums, round to Q16.16, saturate
  // ---------------------------------------------------------------------
  logic [IdxW-1:0]        idx4_q;
  logic signed [PosW-1:0] l4_d [3];
  logic signed [PosW-1:0] l4_q [3];
  logic signed [SumW-1:0] rsum [3];
  logic signed [ShW-1:0]  rsh  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = SumW'(pr3_q[3*i]) + SumW'(pr3_q[3*i+1]) + SumW'(pr3_q[3*i+2])
              + SumW'(32768);
      rsh[i]  = rsum[i][SumW-1:16];
      if (rsh[i] > ShW'(33'sh0_7FFF_FFFF)) begin
        l4_d[i] = {1'b0, {(PosW-1){1'b1}}};
      end else if (rsh[i] < -ShW'(33'sh0_8000_0000)) begin
        l4_d[i] = {1'b1, {(PosW-1){1'b0}}};
      end else begin
        l4_d[i] = rsh[i][PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      idx4_q <= idx3_q;
      l4_q   <= l4_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: magnitudes, squares and the per-axis compares
  // ---------------------------------------------------------------------
  logic [IdxW-1:0]        idx5_q;
  logic signed [PosW-1:0] l5_q [3];
  logic [SqW-1:0]         mx_sq5_q, mz_sq5_q;
  logic                   box5_q, ylt5_q;
  logic [PosW-1:0]        mag [3];
  logic                   box_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = l4_q[i][PosW-1] ? (~l4_q[i] + PosW'(1)) : l4_q[i];
    end
    box_d = ({mag[0], 1'b0} <= (PosW+1)'(ext_q[0])) &&
            ({mag[1], 1'b0} <= (PosW+1)'(ext_q[1])) &&
            ({mag[2], 1'b0} <= (PosW+1)'(ext_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      idx5_q   <= idx4_q;
      l5_q     <= l4_q;
      mx_sq5_q <= mag[0] * mag[0];
      mz_sq5_q <= mag[2] * mag[2];
      box5_q   <= box_d;
      ylt5_q   <= mag[1] < PosW'(ext_q[1]);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: shape decision, output register
  // ---------------------------------------------------------------------
  logic [IdxW-1:0]        idx6_q;
  logic                   att6_q;
  logic signed [PosW-1:0] l6_q [3];
  logic [SqW:0]           rr;
  logic                   att_d;

  always_comb begin
    rr = (SqW+1)'(mx_sq5_q) + (SqW+1)'(mz_sq5_q);
    unique case (shape_q)
      ShapeBox:      att_d = box5_q;
      ShapeCylinder: att_d = ylt5_q && (rr < (SqW+1)'(ex_sq_q));
      default:       att_d = 1'b0;   // sphere and unused code
    endcase
    if ((IdxW+1)'(idx5_q) >= (IdxW+1)'(MaxParticles)) begin
      att_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6 && v5_q) begin
      idx6_q <= idx5_q;
      att6_q <= att_d;
      l6_q   <= l5_q;
    end
  end

  assign m_axis_tvalid = v6_q;
  assign m_axis_tdata  = {7'd0, l6_q[2], l6_q[1], l6_q[0], att6_q, idx6_q};

endmodule

// ===== tb/sv/attachment_point_selector_tb.sv =====
// Self-checking testbench for the attachment point selector stream block.
`timescale 1ns / 1ps

module attachment_point_selector_tb;
  import aps_pkg::*;

  // Run shape
  localparam int unsigned CycleLimit = 1_000_000; // several times the slowest legal run
  localparam int unsigned PhaseBeats = 180;       // random beats per register setting
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned HoldAt     = 120;       // results seen before the long hold-off
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 20;        // pipeline is six deep; wait a bit longer

  // Shape code with no name in the package; must behave like sphere
  localparam logic [1:0] ShapeSpare = 2'd3;

  localparam logic signed [PosW-1:0] PosMax = 32'sh7FFF_FFFF;
  localparam logic signed [PosW-1:0] PosMin = 32'sh8000_0000;

  // One result beat as the block should produce it
  typedef struct packed {
    logic [IdxW-1:0]        idx;
    logic                   att;
    logic signed [PosW-1:0] lx;
    logic signed [PosW-1:0] ly;
    logic signed [PosW-1:0] lz;
  } local_pt_t;

  // Directed step: either a register write or a particle beat
  typedef struct {
    bit                     is_write;
    cfg_reg_e               sel;
    logic [CfgW-1:0]        val;
    logic [IdxW-1:0]        idx;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic signed [PosW-1:0] pz;
    bit                     typed;   // want holds a hand-worked result
    local_pt_t              want;
  } step_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_index_i;
  logic [63:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // [15:0] particle_index, [47:16] particle_x, [79:48] particle_y,
  // [111:80] particle_z
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [15:0] result_index, [16] attached, [48:17] local_x, [80:49] local_y,
  // [112:81] local_z, [119:113] zero
  logic [119:0] m_axis_tdata;

  // Mirror of the block's registers, updated as the bench writes them
  logic signed [PosW-1:0] body_x, body_y, body_z;
  logic [RotW-1:0]        body_rot;
  logic [1:0]             shape_sel;
  logic [ExtW-1:0]        ext_x, ext_y, ext_z;

  local_pt_t   pending[$];      // results owed by the block, oldest first
  step_t       steps[$];        // directed table
  int unsigned err_cnt      = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;
  bit          idle_on      = 1'b1;  // random gaps on both sides when set

  attachment_point_selector DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop if the pipeline hangs
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("attachment_point_selector: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic logic signed [PosW-1:0] clamp32(longint v);
    if (v > longint'(PosMax)) return PosMax;
    if (v < longint'(PosMin)) return PosMin;
    return v[PosW-1:0];
  endfunction

  // World point -> body frame, plus the containment flag for the current shape
  function automatic local_pt_t locate(logic [IdxW-1:0] idx, logic signed [PosW-1:0] px,
                                       logic signed [PosW-1:0] py,
                                       logic signed [PosW-1:0] pz);
    longint    dx, dy, dz, w, a, b, c, unit;
    longint    r00, r01, r02, r10, r11, r12, r20, r21, r22;
    longint    mx, my, mz;
    logic [63:0] ux, uz, rr, rad2;
    local_pt_t res;
    dx = longint'(clamp32(longint'(px) - longint'(body_x)));
    dy = longint'(clamp32(longint'(py) - longint'(body_y)));
    dz = longint'(clamp32(longint'(pz) - longint'(body_z)));
    w = longint'($signed(body_rot[63:48]));
    a = longint'($signed(body_rot[47:32]));
    b = longint'($signed(body_rot[31:16]));
    c = longint'($signed(body_rot[15:0]));
    unit = longint'(1) << 28;
    // Q4.28 matrix entries, rounded to Q16; quaternion taken as-is (no normalize)
    r00 = (unit - 2 * (b * b + c * c) + 2048) >>> 12;
    r01 = (2 * (a * b - w * c) + 2048) >>> 12;
    r02 = (2 * (a * c + w * b) + 2048) >>> 12;
    r10 = (2 * (a * b + w * c) + 2048) >>> 12;
    r11 = (unit - 2 * (a * a + c * c) + 2048) >>> 12;
    r12 = (2 * (b * c - w * a) + 2048) >>> 12;
    r20 = (2 * (a * c - w * b) + 2048) >>> 12;
    r21 = (2 * (b * c + w * a) + 2048) >>> 12;
    r22 = (unit - 2 * (a * a + b * b) + 2048) >>> 12;
    // Transpose applied: column k of R dotted with d
    res.idx = idx;
    res.lx  = clamp32((r00 * dx + r10 * dy + r20 * dz + 32768) >>> 16);
    res.ly  = clamp32((r01 * dx + r11 * dy + r21 * dz + 32768) >>> 16);
    res.lz  = clamp32((r02 * dx + r12 * dy + r22 * dz + 32768) >>> 16);
    mx = longint'(res.lx);
    my = longint'(res.ly);
    mz = longint'(res.lz);
    if (mx < 0) mx = -mx;
    if (my < 0) my = -my;
    if (mz < 0) mz = -mz;
    unique case (shape_sel)
      ShapeBox: begin
        // inclusive against half extents
        res.att = (2 * mx <= longint'(ext_x)) && (2 * my <= longint'(ext_y)) &&
                  (2 * mz <= longint'(ext_z));
      end
      ShapeCylinder: begin
        // strict on both height and radius; sum can reach 2^63, keep unsigned
        ux   = mx;
        uz   = mz;
        rr   = ux * ux + uz * uz;
        rad2 = {33'b0, ext_x} * {33'b0, ext_x};
        res.att = (my < longint'(ext_y)) && (rr < rad2);
      end
      default: begin
        // sphere and the spare code never attach
        res.att = 1'b0;
      end
    endcase
    // A 16-bit index is always below MaxParticles, so no index gate here
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("[%0t] %s: got %0h, expected %0h", $time, what, got, exp);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin : result_check
    local_pt_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing pending", m_axis_tdata[63:0], '0);
      end else begin
        want = pending.pop_front();
        if (m_axis_tdata[15:0] !== want.idx)
          report_mismatch("result_index", 64'(m_axis_tdata[15:0]), 64'(want.idx));
        if (m_axis_tdata[16] !== want.att)
          report_mismatch("attached", 64'(m_axis_tdata[16]), 64'(want.att));
        if (m_axis_tdata[48:17] !== want.lx)
          report_mismatch("local_x", {32'b0, m_axis_tdata[48:17]}, {32'b0, want.lx});
        if (m_axis_tdata[80:49] !== want.ly)
          report_mismatch("local_y", {32'b0, m_axis_tdata[80:49]}, {32'b0, want.ly});
        if (m_axis_tdata[112:81] !== want.lz)
          report_mismatch("local_z", {32'b0, m_axis_tdata[112:81]}, {32'b0, want.lz});
        if (m_axis_tdata[119:113] !== '0)
          report_mismatch("tdata pad", 64'(m_axis_tdata[119:113]), '0);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Register write at a falling edge, mirrored into the predictor state.
  // Only called with the pipeline empty.
  task automatic write_reg(cfg_reg_e sel, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val;
    unique case (sel)
      CfgBodyPosX:  body_x    = val[PosW-1:0];
      CfgBodyPosY:  body_y    = val[PosW-1:0];
      CfgBodyPosZ:  body_z    = val[PosW-1:0];
      CfgBodyRot:   body_rot  = val[RotW-1:0];
      CfgShapeMode: shape_sel = val[1:0];
      CfgExtentX:   ext_x     = val[ExtW-1:0];
      CfgExtentY:   ext_y     = val[ExtW-1:0];
      CfgExtentZ:   ext_z     = val[ExtW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop tvalid and wait until every owed result has come back
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
  endtask

  // Offer one particle beat; record what it owes once accepted
  task automatic send_particle(logic [IdxW-1:0] idx, logic signed [PosW-1:0] px,
                               logic signed [PosW-1:0] py, logic signed [PosW-1:0] pz,
                               bit typed, local_pt_t want);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    pending.insert(pending.size(), typed ? want : locate(idx, px, py, pz));
  endtask

  // Append one row to the directed table
  task automatic add_step(step_t s);
    steps.insert(steps.size(), s);
  endtask

  function automatic step_t reg_row(cfg_reg_e sel, logic [CfgW-1:0] val);
    step_t s;
    s          = '{sel: CfgBodyPosX, default: '0};
    s.is_write = 1'b1;
    s.sel      = sel;
    s.val      = val;
    return s;
  endfunction

  function automatic step_t beat_row(logic [IdxW-1:0] idx, logic signed [PosW-1:0] px,
                                     logic signed [PosW-1:0] py,
                                     logic signed [PosW-1:0] pz, bit typed, logic att,
                                     logic signed [PosW-1:0] lx,
                                     logic signed [PosW-1:0] ly,
                                     logic signed [PosW-1:0] lz);
    step_t s;
    s       = '{sel: CfgBodyPosX, default: '0};
    s.idx   = idx;
    s.px    = px;
    s.py    = py;
    s.pz    = pz;
    s.typed = typed;
    s.want  = '{idx: idx, att: att, lx: lx, ly: ly, lz: lz};
    return s;
  endfunction

  // Roughly unit quaternion in Q2.14 from a random direction in 4-space
  function automatic logic [RotW-1:0] rand_unit_rotation();
    real                    q[4];
    real                    n;
    logic signed [QuatW-1:0] part[4];
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      q[i] = $itor($urandom_range(0, 2000)) / 1000.0 - 1.0;
      n   += q[i] * q[i];
    end
    if (n < 1.0e-4) return RotReset;
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) part[i] = QuatW'($rtoi(q[i] / n * 16383.0));
    return {part[0], part[1], part[2], part[3]};
  endfunction

  function automatic logic [ExtW-1:0] rand_extent();
    logic [ExtW-1:0] e;
    e = ExtW'($urandom);
    return e >> $urandom_range(6, 30);
  endfunction

  function automatic logic signed [PosW-1:0] rand_body_pos();
    logic signed [PosW-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 1) == 0) return v;
    return v >>> $urandom_range(0, 24);
  endfunction

  // Coordinate within +-span of a base; wraps at the ends on purpose
  function automatic logic signed [PosW-1:0] near_pos(logic signed [PosW-1:0] base,
                                                      longint span);
    longint off;
    off = longint'($urandom_range(0, 32'(2 * span))) - span;
    return PosW'(longint'(base) + off);
  endfunction

  // Register setting for one random phase: first two at the extremes
  task automatic program_phase(int p);
    int r;
    if (p == 0) begin
      write_reg(CfgBodyPosX, CfgW'(PosMax));
      write_reg(CfgBodyPosY, CfgW'(PosMax));
      write_reg(CfgBodyPosZ, CfgW'(PosMax));
      write_reg(CfgBodyRot, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(CfgShapeMode, CfgW'(ShapeBox));
      write_reg(CfgExtentX, CfgW'(31'h7FFF_FFFF));
      write_reg(CfgExtentY, CfgW'(31'h7FFF_FFFF));
      write_reg(CfgExtentZ, CfgW'(31'h7FFF_FFFF));
    end else if (p == 1) begin
      write_reg(CfgBodyPosX, {32'b0, PosMin});
      write_reg(CfgBodyPosY, {32'b0, PosMin});
      write_reg(CfgBodyPosZ, {32'b0, PosMin});
      write_reg(CfgBodyRot, 64'h8000_8000_8000_8000);
      write_reg(CfgShapeMode, CfgW'(ShapeCylinder));
      write_reg(CfgExtentX, CfgW'(31'h7FFF_FFFF));
      write_reg(CfgExtentY, CfgW'(31'h7FFF_FFFF));
      write_reg(CfgExtentZ, '0);
    end else begin
      write_reg(CfgBodyPosX, {32'b0, rand_body_pos()});
      write_reg(CfgBodyPosY, {32'b0, rand_body_pos()});
      write_reg(CfgBodyPosZ, {32'b0, rand_body_pos()});
      r = $urandom_range(0, 9);
      if (r < 6)      write_reg(CfgBodyRot, rand_unit_rotation());
      else if (r < 8) write_reg(CfgBodyRot, RotReset);
      else            write_reg(CfgBodyRot, {$urandom, $urandom});   // non-unit, raw
      r = $urandom_range(0, 9);
      if (r < 4)      write_reg(CfgShapeMode, CfgW'(ShapeBox));
      else if (r < 8) write_reg(CfgShapeMode, CfgW'(ShapeCylinder));
      else if (r < 9) write_reg(CfgShapeMode, CfgW'(ShapeSphere));
      else            write_reg(CfgShapeMode, CfgW'(ShapeSpare));
      write_reg(CfgExtentX, CfgW'(rand_extent()));
      write_reg(CfgExtentY, CfgW'(rand_extent()));
      write_reg(CfgExtentZ, CfgW'(rand_extent()));
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off so the pipe backs up
  // into the input while the sender keeps offering beats.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int unsigned low_left;
    int unsigned hold_left;
    bit          hold_done;
    low_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HoldAt) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (low_left > 0) begin
        m_axis_tready <= 1'b0;
        low_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) low_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    local_pt_t              none;
    longint                 span;
    logic signed [PosW-1:0] px, py, pz;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgBodyPosX;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    none          = '0;

    // Register state right after reset
    body_x    = '0;
    body_y    = '0;
    body_z    = '0;
    body_rot  = RotReset;
    shape_sel = ShapeBox;
    ext_x     = '0;
    ext_y     = '0;
    ext_z     = '0;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. With reset registers the rotation is identity and the box
    // has zero size, so local equals offset and only the origin is inside.
    add_step(beat_row(16'h0000, 0, 0, 0, 1, 1'b1, 0, 0, 0));
    add_step(beat_row(16'hFFFF, 1, 0, 0, 1, 1'b0, 1, 0, 0));
    add_step(beat_row(16'h1234, PosMin, PosMax, 0, 1, 1'b0, PosMin, PosMax, 0));
    add_step(beat_row(16'hAAAA, 0, 0, -1, 1, 1'b0, 0, 0, -1));
    // offset saturates low
    add_step(reg_row(CfgBodyPosX, CfgW'(PosMax)));
    add_step(beat_row(16'h5555, PosMin, 0, 0, 1, 1'b0, PosMin, 0, 0));
    // offset saturates high on x, y and low on z
    add_step(reg_row(CfgBodyPosX, {32'b0, PosMin}));
    add_step(reg_row(CfgBodyPosY, {32'b0, PosMin}));
    add_step(reg_row(CfgBodyPosZ, 64'd1));
    add_step(beat_row(16'h00FF, PosMax, PosMax, PosMin, 1, 1'b0,
                      PosMax, PosMax, PosMin));
    // box edges are inclusive
    add_step(reg_row(CfgBodyPosX, '0));
    add_step(reg_row(CfgBodyPosY, '0));
    add_step(reg_row(CfgBodyPosZ, '0));
    add_step(reg_row(CfgExtentX, 64'h2_0000));
    add_step(reg_row(CfgExtentY, 64'h4_0000));
    add_step(reg_row(CfgExtentZ, 64'h7FFF_FFFF));
    add_step(beat_row(16'h0007, 32'sh1_0000, -32'sh2_0000, -32'sh3FFF_FFFF, 1, 1'b1,
                      32'sh1_0000, -32'sh2_0000, -32'sh3FFF_FFFF));
    add_step(beat_row(16'h0008, 32'sh1_0001, 0, 0, 1, 1'b0, 32'sh1_0001, 0, 0));
    add_step(beat_row(16'h0009, 0, 0, PosMin, 1, 1'b0, 0, 0, PosMin));
    // sphere and the spare code never attach, even at the origin
    add_step(reg_row(CfgShapeMode, CfgW'(ShapeSphere)));
    add_step(beat_row(16'h0010, 0, 0, 0, 1, 1'b0, 0, 0, 0));
    add_step(reg_row(CfgShapeMode, CfgW'(ShapeSpare)));
    add_step(beat_row(16'h0011, 0, 0, 0, 1, 1'b0, 0, 0, 0));
    // cylinder: radius 5, half height 3, both bounds strict
    add_step(reg_row(CfgShapeMode, CfgW'(ShapeCylinder)));
    add_step(reg_row(CfgExtentX, 64'h5_0000));
    add_step(reg_row(CfgExtentY, 64'h3_0000));
    add_step(beat_row(16'h0020, 32'sh3_0000, 0, 32'sh4_0000, 1, 1'b0,
                      32'sh3_0000, 0, 32'sh4_0000));
    add_step(beat_row(16'h0021, 32'sh3_0000, 32'sh2_FFFF, 32'sh3_FFFF, 1, 1'b1,
                      32'sh3_0000, 32'sh2_FFFF, 32'sh3_FFFF));
    add_step(beat_row(16'h0022, 0, 32'sh3_0000, 0, 1, 1'b0, 0, 32'sh3_0000, 0));
    add_step(beat_row(16'h0023, 0, -32'sh2_FFFF, 0, 1, 1'b1, 0, -32'sh2_FFFF, 0));
    // non-unit quaternion at the word extremes; output saturation
    add_step(reg_row(CfgBodyRot, 64'h7FFF_8000_1234_C000));
    add_step(beat_row(16'h0030, PosMax, PosMin, PosMax, 0, 1'b0, 0, 0, 0));
    add_step(beat_row(16'h0031, 32'sh1234_5678, -32'sh1000, 32'sh0765_4321,
                      0, 1'b0, 0, 0, 0));
    // 90 degrees about z
    add_step(reg_row(CfgBodyRot, 64'h2D41_0000_0000_2D41));
    add_step(beat_row(16'h0032, 32'sh1_0000, 0, 0, 0, 1'b0, 0, 0, 0));
    // widest cylinder; squared radius against a full-scale point
    add_step(reg_row(CfgExtentX, 64'h7FFF_FFFF));
    add_step(reg_row(CfgExtentY, 64'h7FFF_FFFF));
    add_step(beat_row(16'h0033, PosMin, 0, PosMin, 0, 1'b0, 0, 0, 0));

    foreach (steps[i]) begin
      if (steps[i].is_write) begin
        settle();
        write_reg(steps[i].sel, steps[i].val);
      end else begin
        send_particle(steps[i].idx, steps[i].px, steps[i].py, steps[i].pz,
                      steps[i].typed, steps[i].want);
      end
    end

    // Random phases. Most particles land near the body so the containment
    // test sees both outcomes; the rest are anywhere in the coordinate range.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      idle_on = (p != 3) && (p != 6);
      program_phase(p);
      span = longint'(ext_x);
      if (longint'(ext_y) > span) span = longint'(ext_y);
      if (longint'(ext_z) > span) span = longint'(ext_z);
      span = span + 256;
      if (span > 64'sh7FFF_0000) span = 64'sh7FFF_0000;
      repeat (PhaseBeats) begin
        if ($urandom_range(0, 9) < 7) begin
          px = near_pos(body_x, span);
          py = near_pos(body_y, span);
          pz = near_pos(body_z, span);
        end else begin
          px = $urandom;
          py = $urandom;
          pz = $urandom;
        end
        send_particle(IdxW'($urandom), px, py, pz, 0, none);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("attachment_point_selector: match");
    end else begin
      $display("attachment_point_selector: mismatch");
    end
    $finish;
  end

endmodule
